>>> rtl/jsu_pkg.sv
// Shared types, constants and decode functions for the JSON string unescape unit.
package jsu_pkg;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LO_B   = 8'h62;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_LO_N   = 8'h6E;
	localparam logic [7:0] CH_LO_R   = 8'h72;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_LO_U   = 8'h75;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_STR  = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IN      = 3'd0,
		ST_CLOSED  = 3'd1,
		ST_NOQUOTE = 3'd2,
		ST_BADESC  = 3'd3,
		ST_BADHEX  = 3'd4,
		ST_TRUNC   = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		status_t    status;
		logic       last;
	} result_t;

	// One decoded input: up to three bytes, all sharing one status.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            byte_valid;
		status_t         status;
	} job_t;

	// {invalid, value}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
		return r;
	endfunction

	// {known, byte} for single-byte escapes
	function automatic logic [8:0] esc_value(input logic [7:0] c);
		logic [8:0] r;
		unique case (c)
			CH_QUOTE:  r = {1'b1, CH_QUOTE};
			CH_BSLASH: r = {1'b1, CH_BSLASH};
			CH_SLASH:  r = {1'b1, CH_SLASH};
			CH_LO_B:   r = {1'b1, CH_BS};
			CH_LO_F:   r = {1'b1, CH_FF};
			CH_LO_N:   r = {1'b1, CH_LF};
			CH_LO_R:   r = {1'b1, CH_CR};
			CH_LO_T:   r = {1'b1, CH_TAB};
			default:   r = 9'h000;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/jsu_front.sv
// Front end: string state machine, escape and hex decode, UTF-8 encode into jobs.
module jsu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  jsu_pkg::item_t item,
	output jsu_pkg::job_t  job
);
	import jsu_pkg::*;

	mode_t       mode_q, mode_d;
	logic [1:0]  seen_q, seen_d;
	logic [11:0] cp_q, cp_d;   // only the low 12 bits survive to the last digit
	logic [4:0]  hv;
	logic [8:0]  ev;
	logic [15:0] cp_full;
	logic [7:0]  c;
	logic        fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			seen_q <= '0;
			cp_q   <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			seen_q <= seen_d;
			cp_q   <= cp_d;
		end
	end

	always_comb begin
		c       = item.in_byte;
		fin     = item.final_byte;
		hv      = hex_value(c);
		ev      = esc_value(c);
		cp_full = {cp_q, hv[3:0]};
		mode_d  = mode_q;
		seen_d  = seen_q;
		cp_d    = cp_q;
		job     = '{bytes: '0, last_idx: 2'd0, byte_valid: 1'b0, status: ST_IN};
		unique case (mode_q)
			MODE_IDLE: begin
				if (c != CH_QUOTE) job.status = ST_NOQUOTE;
				else if (fin) job.status = ST_TRUNC;
				else mode_d = MODE_STR;
			end
			MODE_STR: begin
				if (c == CH_QUOTE) begin
					job.status = ST_CLOSED;
					mode_d     = MODE_IDLE;
				end else if (fin) begin
					job.status = ST_TRUNC;
					mode_d     = MODE_IDLE;
				end else if (c == CH_BSLASH) begin
					mode_d = MODE_ESC;
				end else begin
					job.bytes[0]   = c;
					job.byte_valid = 1'b1;
				end
			end
			MODE_ESC: begin
				if (c == CH_LO_U) begin
					if (fin) begin
						job.status = ST_TRUNC;
						mode_d     = MODE_IDLE;
					end else begin
						mode_d = MODE_HEX;
					end
					seen_d = '0;
					cp_d   = '0;
				end else if (!ev[8]) begin
					job.status = ST_BADESC;
					mode_d     = MODE_IDLE;
				end else if (fin) begin
					job.status = ST_TRUNC;
					mode_d     = MODE_IDLE;
				end else begin
					job.bytes[0]   = ev[7:0];
					job.byte_valid = 1'b1;
					mode_d         = MODE_STR;
				end
			end
			MODE_HEX: begin
				if (hv[4]) begin
					job.status = ST_BADHEX;
					mode_d     = MODE_IDLE;
					seen_d     = '0;
					cp_d       = '0;
				end else if (fin) begin
					job.status = ST_TRUNC;
					mode_d     = MODE_IDLE;
					seen_d     = '0;
					cp_d       = '0;
				end else if (seen_q != 2'd3) begin
					cp_d   = cp_full[11:0];
					seen_d = seen_q + 2'd1;
				end else begin
					mode_d         = MODE_STR;
					seen_d         = '0;
					cp_d           = '0;
					job.byte_valid = 1'b1;
					if (cp_full < 16'h0080) begin
						job.bytes[0] = cp_full[7:0];
					end else if (cp_full < 16'h0800) begin
						job.bytes[0] = {3'b110, cp_full[10:6]};
						job.bytes[1] = {2'b10, cp_full[5:0]};
						job.last_idx = 2'd1;
					end else begin
						job.bytes[0] = {4'b1110, cp_full[15:12]};
						job.bytes[1] = {2'b10, cp_full[11:6]};
						job.bytes[2] = {2'b10, cp_full[5:0]};
						job.last_idx = 2'd2;
					end
				end
			end
			default: mode_d = MODE_IDLE;
		endcase
	end

endmodule

>>> rtl/jsu_queue.sv
// Small job queue between the front end and the back end.
module jsu_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  jsu_pkg::job_t wr_job,
	input  logic          rd,
	output jsu_pkg::job_t rd_job,
	output logic          full,
	output logic          empty
);
	import jsu_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full   = (cnt_q == FULL_CNT);
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == LAST_PTR) ? '0 : wp_q + PW'(1);
			if (rd) rp_q <= (rp_q == LAST_PTR) ? '0 : rp_q + PW'(1);
			if (wr && !rd) cnt_q <= cnt_q + CW'(1);
			else if (rd && !wr) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

>>> rtl/jsu_back.sv
// Back end: holds one job and hands out its result words one per pop.
module jsu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jsu_pkg::job_t    job,
	input  logic             job_avail,
	output logic             job_take,
	input  logic             pop,
	output logic             empty,
	output jsu_pkg::result_t result
);
	import jsu_pkg::*;

	job_t       cur_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       is_last;
	logic       done;

	assign is_last  = (idx_q == cur_q.last_idx);
	assign done     = pop && valid_q && is_last;
	assign job_take = job_avail && (!valid_q || done);
	assign empty    = !valid_q;

	always_comb begin
		case (idx_q)
			2'd1:    result.out_byte = cur_q.bytes[1];
			2'd2:    result.out_byte = cur_q.bytes[2];
			default: result.out_byte = cur_q.bytes[0];
		endcase
		result.byte_valid = cur_q.byte_valid;
		result.status     = cur_q.status;
		result.last       = is_last;
	end

	always_ff @(posedge clk) begin
		if (job_take) cur_q <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (job_take) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (pop && valid_q) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

>>> rtl/json_string_unescape_unit.sv
// Top level of the JSON string unescape unit: front end, job queue, back end.
//
// Input channel: push/full with an item word (in_byte, final_byte). A word is
//   taken at a clock edge with push high and full low. One word per cycle is
//   taken as long as the job queue has room.
// Result channel: empty/pop with a result word (out_byte, byte_valid, status,
//   last). While empty is low the oldest result sits on the port; pop takes it.
// Every input word becomes one job in the front end in the cycle it is taken:
//   one to three result words, the final one marked by last.
// With queue and back end idle, the job of a taken input word is written into
//   the job queue, then loaded into the back end; its first result word is then
//   on the port, where pop can take it.
// Throughput: one result word per cycle while pop stays high. Every input
//   gives at least one word, so input runs one per cycle only while words per
//   input average one; a \u escape gives up to eight words from six inputs,
//   so long runs are paced by the result side; the queue fills and full rises.
// The job queue (QUEUE_DEPTH entries) decouples the two sides: if pop stays
//   low, results wait and input continues until the queue fills, then full rises.
// Reset (arst_n low) returns the decoder to idle (awaiting an opening quote)
//   and drops every queued and pending result.
module json_string_unescape_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  jsu_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output jsu_pkg::result_t result
);
	import jsu_pkg::*;

	logic accept;
	job_t fe_job;     // decoded job from the front end
	job_t q_job;      // head of the job queue
	logic q_empty;
	logic q_take;

	assign accept = push && !full;

	// Decoder state machine; classifies each accepted word
	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.job    (fe_job)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wr_job (fe_job),
		.rd     (q_take),
		.rd_job (q_job),
		.full   (full),
		.empty  (q_empty)
	);

	// Serializes each job into its result words
	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (q_job),
		.job_avail (!q_empty),
		.job_take  (q_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

>>> verif/tb.sv
// Self-checking testbench for the JSON string unescape unit: directed and random byte streams.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import jsu_pkg::*;

	// Stimulus sizing and run guards
	localparam int RANDOM_WORDS = 300;
	localparam int QUIET_AFTER  = 240;    // no idling on either side past this many random words
	localparam int DRAIN_CYCLES = 20;     // a 4-deep queue plus the back end register, with margin
	localparam int CYCLE_LIMIT  = 200000;

	// The eight single-byte escape letters, indexed 0..7
	localparam logic [7:0][7:0] ESC_LETTERS = {
		CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LO_B, CH_LO_F, CH_LO_N, CH_LO_R, CH_LO_T
	};

	// Scoreboard: a bit-accurate copy of the decoder plus the queue of result words it
	// predicts. decode() runs on every accepted input word, compare() on every popped one.
	class unescape_scoreboard;
		mode_t       mode;
		logic [1:0]  digits_seen;
		logic [15:0] code_point;
		result_t     decoded_words[$];
		int          errors;

		function new();
			errors = 0;
			go_idle();
		endfunction

		function void go_idle();
			mode = MODE_IDLE;
			digits_seen = 2'd0;
			code_point = 16'h0000;
		endfunction

		// One word with no data byte, just the status
		function void add_status(status_t st);
			result_t r;
			r.out_byte = 8'h00;
			r.byte_valid = 1'b0;
			r.status = st;
			r.last = 1'b1;
			decoded_words = {decoded_words, r};
		endfunction

		// n data bytes, b[0] first, last flag on the final one
		function void add_bytes(logic [2:0][7:0] b, int n);
			result_t r;
			for (int k = 0; k < n; k++) begin
				r.out_byte = b[k];
				r.byte_valid = 1'b1;
				r.status = ST_IN;
				r.last = (k == n - 1);
				decoded_words = {decoded_words, r};
			end
		endfunction

		// {not_hex, value}
		function logic [4:0] nibble(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
			if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
				return {1'b0, c[3:0] + 4'd9};
			return 5'h10;
		endfunction

		function void decode(item_t w);
			logic [7:0]  c;
			logic        fin;
			logic [4:0]  d;
			logic [7:0]  esc;
			logic        known;
			logic [15:0] cp;
			c = w.in_byte;
			fin = w.final_byte;
			case (mode)
				MODE_IDLE: begin
					// anything but a quote is rejected and leaves the decoder idle
					if (c != CH_QUOTE) add_status(ST_NOQUOTE);
					else if (fin) add_status(ST_TRUNC);
					else begin
						mode = MODE_STR;
						add_status(ST_IN);
					end
				end
				MODE_STR: begin
					if (c == CH_QUOTE) begin
						go_idle();
						add_status(ST_CLOSED);
					end else if (fin) begin
						go_idle();
						add_status(ST_TRUNC);
					end else if (c == CH_BSLASH) begin
						mode = MODE_ESC;
						add_status(ST_IN);
					end else begin
						add_bytes({16'h0000, c}, 1);
					end
				end
				MODE_ESC: begin
					known = 1'b1;
					esc = 8'h00;
					case (c)
						CH_QUOTE, CH_BSLASH, CH_SLASH: esc = c;
						CH_LO_B: esc = CH_BS;
						CH_LO_F: esc = CH_FF;
						CH_LO_N: esc = CH_LF;
						CH_LO_R: esc = CH_CR;
						CH_LO_T: esc = CH_TAB;
						default: known = 1'b0;
					endcase
					if (c == CH_LO_U) begin
						if (fin) begin
							go_idle();
							add_status(ST_TRUNC);
						end else begin
							mode = MODE_HEX;
							digits_seen = 2'd0;
							code_point = 16'h0000;
							add_status(ST_IN);
						end
					end else if (!known) begin
						// bad escape wins over end of input
						go_idle();
						add_status(ST_BADESC);
					end else if (fin) begin
						go_idle();
						add_status(ST_TRUNC);
					end else begin
						mode = MODE_STR;
						add_bytes({16'h0000, esc}, 1);
					end
				end
				default: begin
					d = nibble(c);
					if (d[4]) begin
						// bad hex wins over end of input
						go_idle();
						add_status(ST_BADHEX);
					end else if (fin) begin
						go_idle();
						add_status(ST_TRUNC);
					end else begin
						code_point = {code_point[11:0], d[3:0]};
						if (digits_seen != 2'd3) begin
							digits_seen++;
							add_status(ST_IN);
						end else begin
							cp = code_point;
							go_idle();
							mode = MODE_STR;
							// UTF-8, surrogates encoded alone as three bytes
							if (cp < 16'h0080)
								add_bytes({16'h0000, cp[7:0]}, 1);
							else if (cp < 16'h0800)
								add_bytes({8'h00, {2'b10, cp[5:0]}, {3'b110, cp[10:6]}}, 2);
							else
								add_bytes({{2'b10, cp[5:0]}, {2'b10, cp[11:6]},
									{4'b1110, cp[15:12]}}, 3);
						end
					end
				end
			endcase
		endfunction

		function void compare(result_t got);
			result_t want;
			if (decoded_words.size() == 0) begin
				$error("unexpected result word: out_byte %h byte_valid %b status %0d last %b",
					got.out_byte, got.byte_valid, got.status, got.last);
				errors++;
				return;
			end
			want = decoded_words.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.byte_valid !== want.byte_valid) begin
				$error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %b, got %b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	// DUT-facing signals; every input has a known value from time zero
	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    pop = 1'b0;
	item_t   item = '0;
	logic    full;
	logic    empty;
	result_t result;

	bit      quiet = 1'b0;       // set for the tail of the run: no gaps, no stalls
	int      words_sent = 0;
	int      stall_left = 0;
	int      cycles = 0;

	unescape_scoreboard sb = new();

	json_string_unescape_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #1 clk = ~clk;

	// Hex digit character, upper or lower case for a..f
	function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
		if (v < 4'd10) return 8'h30 + 8'(v);
		return (upper ? 8'h37 : 8'h57) + 8'(v);
	endfunction

	// Push one word. Inputs change only by NBA right after a rising edge; the full
	// read right after the edge is still the value the DUT saw at that edge, so
	// leaving the loop means the word was taken there.
	task automatic send_word(logic [7:0] b, logic fin);
		item_t w;
		int    gap;
		w.in_byte = b;
		w.final_byte = fin;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 14);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		sb.decode(w);
		words_sent++;
	endtask

	// Text as a stream of words, final_byte optionally on the last one
	task automatic send_text(string s, logic fin_at_end);
		for (int k = 0; k < s.len(); k++)
			send_word(s[k], fin_at_end && (k == s.len() - 1));
	endtask

	// A quoted string with random content: plain bytes, simple escapes and \u
	// escapes spread over the 1-, 2- and 3-byte encodings and the surrogate range.
	// About one in ten is cut short by final_byte, one in ten gets a byte corrupted.
	task automatic send_random_string();
		item_t       seq[$];
		int          n;
		int          kind;
		int          idx;
		int          mutate;
		logic [15:0] cp;
		logic [7:0]  b;
		seq = {seq, item_t'({CH_QUOTE, 1'b0})};
		n = $urandom_range(0, 8);
		for (int k = 0; k < n; k++) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BSLASH);
				seq = {seq, item_t'({b, 1'b0})};
			end else if (kind <= 6) begin
				seq = {seq, item_t'({CH_BSLASH, 1'b0})};
				seq = {seq, item_t'({ESC_LETTERS[$urandom_range(0, 7)], 1'b0})};
			end else begin
				case ($urandom_range(0, 3))
					0: cp = 16'($urandom_range(0, 16'h007F));
					1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
					2: cp = 16'($urandom);
					default: cp = 16'hD800 + 16'($urandom_range(0, 16'h07FF));
				endcase
				seq = {seq, item_t'({CH_BSLASH, 1'b0})};
				seq = {seq, item_t'({CH_LO_U, 1'b0})};
				for (int j = 3; j >= 0; j--)
					seq = {seq, item_t'({hex_char(cp[j*4 +: 4], 1'($urandom_range(0, 1))),
						1'b0})};
			end
		end
		// final_byte on the closing quote is a don't-care for the decoder
		seq = {seq, item_t'({CH_QUOTE, 1'($urandom_range(0, 1))})};
		mutate = $urandom_range(0, 9);
		if (mutate == 0) begin
			idx = $urandom_range(0, seq.size() - 1);
			seq[idx].final_byte = 1'b1;
			while (seq.size() > idx + 1) void'(seq.pop_back());
		end else if (mutate == 1) begin
			idx = $urandom_range(1, seq.size() - 1);
			seq[idx].in_byte = 8'($urandom);
		end
		foreach (seq[k]) send_word(seq[k].in_byte, seq[k].final_byte);
	endtask

	// Unstructured bytes, final_byte now and then
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int k = 0; k < n; k++)
			send_word(8'($urandom), $urandom_range(0, 3) == 0);
	endtask

	// Result side: check whatever was popped at this edge, then pick pop for the
	// next cycle. Random stalls come in bursts until the quiet tail.
	always @(posedge clk) begin
		if (pop && !empty) sb.compare(result);
		if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 14);
		if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left--;
		end else begin
			pop <= 1'b1;
		end
	end

	// Hang guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int base;
		// reset is held from time zero, released once, never asserted again
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: missing opening quote, quote with end of input
		send_text("a", 1'b0);
		send_text("\"", 1'b1);
		// Open, pass through both byte extremes, then \u in 1-, 2- and 3-byte
		// forms with mixed-case hex (the last a lone high surrogate), close with
		// final_byte set
		send_word(CH_QUOTE, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_text("\\u0041\\u07fF\\uD83d\"", 1'b1);
		// Unknown escape letter, then a bad hex digit
		send_text("\"\\q", 1'b0);
		send_text("\"\\uG", 1'b0);

		// Random: mostly well-formed strings, the rest noise
		base = words_sent;
		while (words_sent - base < RANDOM_WORDS) begin
			if (words_sent - base >= QUIET_AFTER) quiet = 1'b1;
			if ($urandom_range(0, 3) == 0) send_noise();
			else send_random_string();
		end
		push <= 1'b0;

		// Drain: wait for every predicted word, then watch for strays
		while (sb.decoded_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.decoded_words.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
